// File: sv/hdd_pkg.sv
package hdd_pkg;

    localparam int IN_W              = 16;
    localparam int ANG_W             = 16;
    localparam int ERR_W             = 17;
    localparam int ACC_W             = 24;
    localparam int XY_W              = 27;
    localparam int SCALE_SH          = 8;
    localparam int CORDIC_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    localparam logic [ACC_W-1:0] ACC_HALF_TURN = 24'h800000;
    localparam logic [ACC_W-1:0] ACC_ROUND     = 24'd128;
    localparam logic [ERR_W-1:0] HALF_TURN     = 17'd32768;

    localparam logic [1:0] DRIVE_NEG  = 2'b11;
    localparam logic [1:0] DRIVE_HOLD = 2'b00;
    localparam logic [1:0] DRIVE_POS  = 2'b01;

    // Angle of atan(2^-i) at 2^24 units per turn, rounded to nearest.
    localparam logic [ACC_W-1:0] ATAN_TABLE [0:MAX_STAGES-1] = '{
        24'd2097152, 24'd1238021, 24'd654136, 24'd332050,
        24'd166669,  24'd83416,   24'd41718,  24'd20860,
        24'd10430,   24'd5215,    24'd2608,   24'd1304,
        24'd652,     24'd326,     24'd163,    24'd81,
        24'd41,      24'd20,      24'd10,     24'd5,
        24'd3,       24'd1,       24'd1,      24'd0
    };

    typedef logic signed [XY_W-1:0] xy_t;
    typedef logic [ACC_W-1:0]       acc_t;

endpackage

// File: sv/hdd_cordic.sv
module hdd_cordic #(
    parameter int STAGES = hdd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                             clk,
    input  logic [STAGES:0]                  en,
    input  logic signed [hdd_pkg::IN_W-1:0]  x_in,
    input  logic signed [hdd_pkg::IN_W-1:0]  y_in,
    output logic [hdd_pkg::ACC_W-1:0]        acc,
    output logic                             zero
);
    import hdd_pkg::*;

    xy_t  x_reg    [0:STAGES];
    xy_t  y_reg    [0:STAGES];
    acc_t acc_reg  [0:STAGES];
    logic zero_reg [0:STAGES];

    xy_t  x_ext;
    xy_t  y_ext;
    xy_t  x_pre_next;
    xy_t  y_pre_next;
    acc_t acc_pre_next;

    // The vector is folded into the right half plane before the rotations.
    always_comb
    begin
        x_ext = xy_t'(x_in);
        y_ext = xy_t'(y_in);
        if (x_in[IN_W-1])
        begin
            x_pre_next   = (-x_ext) <<< SCALE_SH;
            y_pre_next   = (-y_ext) <<< SCALE_SH;
            acc_pre_next = ACC_HALF_TURN;
        end
        else
        begin
            x_pre_next   = x_ext <<< SCALE_SH;
            y_pre_next   = y_ext <<< SCALE_SH;
            acc_pre_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            x_reg[0]    <= x_pre_next;
            y_reg[0]    <= y_pre_next;
            acc_reg[0]  <= acc_pre_next;
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
        end
    end

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        xy_t dx;
        xy_t dy;

        assign dx = x_reg[i] >>> i;
        assign dy = y_reg[i] >>> i;

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                zero_reg[i+1] <= zero_reg[i];
                if (y_reg[i][XY_W-1])
                begin
                    x_reg[i+1]   <= x_reg[i] - dy;
                    y_reg[i+1]   <= y_reg[i] + dx;
                    acc_reg[i+1] <= acc_reg[i] - ATAN_TABLE[i];
                end
                else
                begin
                    x_reg[i+1]   <= x_reg[i] + dy;
                    y_reg[i+1]   <= y_reg[i] - dx;
                    acc_reg[i+1] <= acc_reg[i] + ATAN_TABLE[i];
                end
            end
        end
    end

    assign acc  = acc_reg[STAGES];
    assign zero = zero_reg[STAGES];

endmodule

// File: sv/heading_deadband_direction.sv
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     ref_x, ref_y, target_x, target_y
// out      output     out_valid / out_ready   drive, heading_error
// cfg      input      cfg_valid / cfg_ready   cfg_data (deadband)
//
// The pipeline has one folding stage, one stage per CORDIC rotation, one stage
// for rounding and subtraction, and the output register.
// One transaction is accepted per cycle while the pipeline moves.
// Reset clears the valid bits and sets the deadband to zero.
// A stall on the output only holds stages that are occupied; empty stages keep
// filling, so bubbles are squeezed out before the input is held back.
module heading_deadband_direction #(
    parameter int CORDIC_STAGES = hdd_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hdd_pkg::IN_W-1:0]   ref_x,
    input  logic signed [hdd_pkg::IN_W-1:0]   ref_y,
    input  logic signed [hdd_pkg::IN_W-1:0]   target_x,
    input  logic signed [hdd_pkg::IN_W-1:0]   target_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [1:0]                 drive,
    output logic signed [hdd_pkg::ERR_W-1:0]  heading_error,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hdd_pkg::ANG_W-1:0]         cfg_data
);
    import hdd_pkg::*;

    localparam int NSTG    = CORDIC_STAGES + 3;
    localparam int SUB_IDX = CORDIC_STAGES + 1;
    localparam int OUT_IDX = CORDIC_STAGES + 2;

    logic [NSTG-1:0]      v_reg;
    logic [NSTG-1:0]      v_next;
    logic [NSTG:0]        ready_s;
    logic [ANG_W-1:0]     deadband_reg;

    acc_t                 ref_acc;
    acc_t                 tgt_acc;
    logic                 ref_zero;
    logic                 tgt_zero;
    acc_t                 ref_round;
    acc_t                 tgt_round;
    logic [ANG_W-1:0]     ref_ang;
    logic [ANG_W-1:0]     tgt_ang;
    logic [ANG_W-1:0]     diff_reg;
    logic [ANG_W-1:0]     diff_next;

    logic [ERR_W-1:0]     err_next;
    logic [ERR_W-1:0]     mag;
    logic [1:0]           drive_next;
    logic [1:0]           drive_reg;
    logic [ERR_W-1:0]     err_reg;

    always_comb
    begin
        ready_s[NSTG] = out_ready;
        for (int k = NSTG - 1; k >= 0; k--)
        begin
            ready_s[k] = !v_reg[k] || ready_s[k+1];
        end
    end

    always_comb
    begin
        v_next[0] = ready_s[0] ? in_valid : v_reg[0];
        for (int k = 1; k < NSTG; k++)
        begin
            v_next[k] = ready_s[k] ? v_reg[k-1] : v_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg        <= '0;
            deadband_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
            if (cfg_valid && cfg_ready)
            begin
                deadband_reg <= cfg_data;
            end
        end
    end

    hdd_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_ref_cordic (
        .clk  (clk),
        .en   (ready_s[CORDIC_STAGES:0]),
        .x_in (ref_x),
        .y_in (ref_y),
        .acc  (ref_acc),
        .zero (ref_zero)
    );

    hdd_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_tgt_cordic (
        .clk  (clk),
        .en   (ready_s[CORDIC_STAGES:0]),
        .x_in (target_x),
        .y_in (target_y),
        .acc  (tgt_acc),
        .zero (tgt_zero)
    );

    // Round half up to 65536 units per turn; the subtraction wraps mod a turn.
    always_comb
    begin
        ref_round = ref_acc + ACC_ROUND;
        tgt_round = tgt_acc + ACC_ROUND;
        ref_ang   = ref_zero ? '0 : ref_round[ACC_W-1:SCALE_SH];
        tgt_ang   = tgt_zero ? '0 : tgt_round[ACC_W-1:SCALE_SH];
        diff_next = tgt_ang - ref_ang;
    end

    always_ff @(posedge clk)
    begin
        if (ready_s[SUB_IDX])
        begin
            diff_reg <= diff_next;
        end
    end

    // Values up to a half turn stay positive, so an exact half turn is +32768.
    always_comb
    begin
        if ({1'b0, diff_reg} <= HALF_TURN)
        begin
            err_next = {1'b0, diff_reg};
        end
        else
        begin
            err_next = {1'b1, diff_reg};
        end
        mag = err_next[ERR_W-1] ? (-err_next) : err_next;
        if (mag > {1'b0, deadband_reg})
        begin
            drive_next = err_next[ERR_W-1] ? DRIVE_NEG : DRIVE_POS;
        end
        else
        begin
            drive_next = DRIVE_HOLD;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_s[OUT_IDX])
        begin
            err_reg   <= err_next;
            drive_reg <= drive_next;
        end
    end

    assign in_ready      = ready_s[0];
    assign out_valid     = v_reg[NSTG-1];
    assign drive         = drive_reg;
    assign heading_error = err_reg;
    assign cfg_ready     = 1'b1;

`ifndef SYNTHESIS
    a_drive_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (drive == DRIVE_HOLD)
                   || (drive == DRIVE_POS && !heading_error[ERR_W-1]
                       && heading_error != '0)
                   || (drive == DRIVE_NEG && heading_error[ERR_W-1]))
        else $error("drive does not match the sign of heading_error");

    a_no_neg_half: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> heading_error != 17'h18000)
        else $error("heading_error holds a negative half turn");

    a_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> in_ready)
        else $error("input held back while the first stage is empty");

    a_out_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTG-2] && !out_valid) |=> out_valid)
        else $error("result did not reach the empty output register");
`endif

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int STAGES  = hdd_pkg::CORDIC_STAGES_DEF;
    localparam int LATENCY = STAGES + 3;
    localparam int W       = hdd_pkg::IN_W;
    localparam int EW      = hdd_pkg::ERR_W;

    typedef struct packed {
        logic signed [W-1:0] ref_x;
        logic signed [W-1:0] ref_y;
        logic signed [W-1:0] tgt_x;
        logic signed [W-1:0] tgt_y;
    } heading_pair_t;

    typedef struct packed {
        logic signed [1:0]    drive;
        logic signed [EW-1:0] heading_error;
    } steer_cmd_t;

    typedef enum int {
        GEN_RANDOM,
        GEN_SMALL,
        GEN_EXTREME,
        GEN_NEAR_EQUAL,
        GEN_DEADBAND_EDGE
    } gen_style_t;

    logic                       clk;
    logic                       rst_n          = 1'b0;
    logic                       in_valid       = 1'b0;
    logic                       in_ready;
    logic signed [W-1:0]        ref_x          = '0;
    logic signed [W-1:0]        ref_y          = '0;
    logic signed [W-1:0]        target_x       = '0;
    logic signed [W-1:0]        target_y       = '0;
    logic                       out_valid;
    logic                       out_ready      = 1'b0;
    logic signed [1:0]          drive;
    logic signed [EW-1:0]       heading_error;
    logic                       cfg_valid      = 1'b0;
    logic                       cfg_ready;
    logic [hdd_pkg::ANG_W-1:0]  cfg_data       = '0;

    heading_pair_t              pending_pairs[$];
    steer_cmd_t                 steer_expected[$];
    logic [hdd_pkg::ANG_W-1:0]  deadband_now   = '0;
    int                         send_idle_pct  = 0;
    int                         recv_stall_pct = 0;
    logic                       hold_out       = 1'b0;
    int                         mismatches     = 0;
    int                         checked        = 0;
    int                         cfg_writes     = 0;

    longint atan_units [0:23] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
        10430, 5215, 2608, 1304, 652, 326, 163, 81,
        41, 20, 10, 5, 3, 1, 1, 0
    };

    heading_deadband_direction #(
        .CORDIC_STAGES (STAGES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .ref_x         (ref_x),
        .ref_y         (ref_y),
        .target_x      (target_x),
        .target_y      (target_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .drive         (drive),
        .heading_error (heading_error),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("timeout: %0d results still pending", steer_expected.size());
        $display("testbench: errors");
        $finish;
    end

    function automatic longint heading_angle(longint vx, longint vy);
        longint acc;
        longint dx;
        longint dy;
        int     i;
        acc = 0;
        if (vx == 0 && vy == 0)
        begin
            return 0;
        end
        if (vx < 0)
        begin
            vx  = -vx;
            vy  = -vy;
            acc = 8388608;
        end
        vx = vx * 256;
        vy = vy * 256;
        for (i = 0; i < STAGES && i < 24; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy < 0)
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - atan_units[i];
            end
            else
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + atan_units[i];
            end
        end
        acc = (acc + 128) >>> 8;
        acc = acc % 65536;
        if (acc < 0)
        begin
            acc = acc + 65536;
        end
        return acc;
    endfunction

    function automatic steer_cmd_t predict_steer(heading_pair_t p,
                                                 logic [hdd_pkg::ANG_W-1:0] band);
        steer_cmd_t c;
        longint     diff;
        longint     mag;
        diff = heading_angle(p.tgt_x, p.tgt_y) - heading_angle(p.ref_x, p.ref_y);
        diff = diff % 65536;
        if (diff < 0)
        begin
            diff = diff + 65536;
        end
        if (diff > 32768)
        begin
            diff = diff - 65536;
        end
        if (diff == -32768)
        begin
            diff = 32768;
        end
        mag = (diff < 0) ? -diff : diff;
        c.drive = hdd_pkg::DRIVE_HOLD;
        if (mag > longint'(band))
        begin
            c.drive = (diff > 0) ? hdd_pkg::DRIVE_POS : hdd_pkg::DRIVE_NEG;
        end
        c.heading_error = diff[EW-1:0];
        return c;
    endfunction

    function automatic logic [W-1:0] small_value();
        int v;
        v = $urandom_range(0, 8);
        return W'(v - 4);
    endfunction

    function automatic logic [W-1:0] extreme_value();
        logic [W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = 16'h8000;
            1:       v = 16'hFFFF;
            2:       v = 16'h0000;
            3:       v = 16'h0001;
            default: v = 16'h7FFF;
        endcase
        return v;
    endfunction

    function automatic heading_pair_t make_pair(gen_style_t style);
        heading_pair_t p;
        longint        ang;
        longint        offset;
        int            jitter;
        real           th;
        real           radius;
        p.ref_x = W'($urandom);
        p.ref_y = W'($urandom);
        p.tgt_x = W'($urandom);
        p.tgt_y = W'($urandom);
        case (style)
            GEN_SMALL:
            begin
                p.ref_x = small_value();
                p.ref_y = small_value();
                p.tgt_x = small_value();
                p.tgt_y = small_value();
            end
            GEN_EXTREME:
            begin
                p.ref_x = extreme_value();
                p.ref_y = extreme_value();
                p.tgt_x = extreme_value();
                p.tgt_y = extreme_value();
            end
            GEN_NEAR_EQUAL:
            begin
                p.tgt_x = p.ref_x + small_value();
                p.tgt_y = p.ref_y + small_value();
            end
            GEN_DEADBAND_EDGE:
            begin
                // Rotate the reference by about the deadband so the error lands on its edge.
                ang    = heading_angle(p.ref_x, p.ref_y);
                jitter = $urandom_range(0, 6);
                offset = longint'(deadband_now) + longint'(jitter) - 3;
                if ($urandom_range(0, 1) == 1)
                begin
                    offset = -offset;
                end
                th     = real'(ang + offset) * 6.283185307179586 / 65536.0;
                radius = real'($urandom_range(1000, 32000));
                p.tgt_x = W'($rtoi(radius * $cos(th)));
                p.tgt_y = W'($rtoi(radius * $sin(th)));
            end
            default:
            begin
            end
        endcase
        return p;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic push_pair(logic signed [W-1:0] rx, logic signed [W-1:0] ry,
                             logic signed [W-1:0] tx, logic signed [W-1:0] ty);
        heading_pair_t p;
        p.ref_x = rx;
        p.ref_y = ry;
        p.tgt_x = tx;
        p.tgt_y = ty;
        pending_pairs.push_back(p);
    endtask

    task automatic load_random(int count);
        int roll;
        gen_style_t style;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                style = GEN_RANDOM;
            end
            else if (roll < 55)
            begin
                style = GEN_SMALL;
            end
            else if (roll < 65)
            begin
                style = GEN_EXTREME;
            end
            else if (roll < 80)
            begin
                style = GEN_NEAR_EQUAL;
            end
            else
            begin
                style = GEN_DEADBAND_EDGE;
            end
            pending_pairs.push_back(make_pair(style));
        end
    endtask

    task automatic drain();
        @(negedge clk);
        while (pending_pairs.size() != 0 || in_valid || steer_expected.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_deadband(logic [hdd_pkg::ANG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid    <= 1'b0;
        deadband_now = value;
        cfg_writes++;
    endtask

    task automatic run_phase(logic [hdd_pkg::ANG_W-1:0] band, int s_idle, int r_stall,
                             int count);
        write_deadband(band);
        @(negedge clk);
        send_idle_pct  = s_idle;
        recv_stall_pct = r_stall;
        load_random(count);
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin : driver
        heading_pair_t cur;
        heading_pair_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            ref_x    <= '0;
            ref_y    <= '0;
            target_x <= '0;
            target_y <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                cur = {ref_x, ref_y, target_x, target_y};
                steer_expected.push_back(predict_steer(cur, deadband_now));
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    nxt = pending_pairs.pop_front();
                    in_valid <= 1'b1;
                    ref_x    <= nxt.ref_x;
                    ref_y    <= nxt.ref_y;
                    target_x <= nxt.tgt_x;
                    target_y <= nxt.tgt_y;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : monitor
        steer_cmd_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (steer_expected.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction: drive %0d error %0d",
                                              drive, heading_error));
                end
                else
                begin
                    want = steer_expected.pop_front();
                    checked++;
                    if (drive !== want.drive)
                    begin
                        report_mismatch($sformatf("drive %0d, predicted %0d",
                                                  drive, want.drive));
                    end
                    if (heading_error !== want.heading_error)
                    begin
                        report_mismatch($sformatf("heading_error %0d, predicted %0d",
                                                  heading_error, want.heading_error));
                    end
                end
            end
            out_ready <= !hold_out && ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Runs at the reset deadband of zero.
        push_pair(0, 0, 0, 0);
        push_pair(0, 0, 32767, 0);
        push_pair(0, 0, 0, 32767);
        push_pair(0, 0, 0, -32768);
        push_pair(1, 0, -1, 0);
        push_pair(-1, 0, 1, 0);
        push_pair(32767, 32767, -32768, -32768);
        push_pair(-32768, 0, 32767, 0);
        push_pair(-32768, -32768, 32767, -32768);
        push_pair(32767, -32768, -32768, 32767);
        push_pair(0, 32767, 0, -32768);
        push_pair(-32768, 32767, -32768, -32768);
        push_pair(-32768, -1, -32768, 1);
        push_pair(5, 5, 5, 5);
        push_pair(32767, 1, 32767, -1);
        push_pair(-1, -1, 0, 0);
        push_pair(1, 1, -1, -1);
        push_pair(-32768, -32768, -32768, -32768);
        push_pair(32767, 32767, 32767, 32767);
        push_pair(-1, 0, -1, 0);
        drain();

        run_phase(16'd0, 0, 0, 150);
        run_phase(16'd1000, 78, 0, 150);
        run_phase(16'd32768, 0, 78, 120);
        run_phase(16'hFFFF, 13, 13, 80);
        run_phase(16'd200, 13, 13, 150);

        // Output held off for a long stretch while the input keeps offering.
        write_deadband(16'd5000);
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_out       = 1'b1;
        load_random(120);
        repeat (400) @(negedge clk);
        hold_out = 1'b0;
        drain();

        run_phase(hdd_pkg::ANG_W'($urandom_range(1, 32767)), 40, 40, 65);
        @(negedge clk);
        send_idle_pct  = 0;
        recv_stall_pct = 20;
        load_random(65);
        drain();

        repeat (LATENCY + 8) @(posedge clk);
        if (steer_expected.size() != 0)
        begin
            report_mismatch($sformatf("%0d predicted results never arrived",
                                      steer_expected.size()));
        end
        $display("summary: %0d transactions checked across %0d deadband writes",
                 checked, cfg_writes);
        $display("summary: zero vectors, axis extremes, half-turn wrap, deadband edges, stalls");
        if (mismatches == 0)
        begin
            $display("testbench: clean");
        end
        else
        begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
sv/hdd_pkg.sv
sv/hdd_cordic.sv
sv/heading_deadband_direction.sv
bench/testbench.sv
